// File: rtl/core/modexp_pkg.sv
// Shared types for the modular exponentiation block.
// Holds the controller state encoding and the command and status bundles
// that pass between controller and datapath. No dependencies.
package modexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_RED_ACC,
    ST_MUL_SQ,
    ST_RED_SQ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sel_acc;
    logic red;
    logic wr_acc;
    logic shift;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic red_last;
  } dp_status_t;

endpackage

// File: rtl/core/modexp_ctrl.sv
// Controller for the modular exponentiation block.
// Sequences multiply, reduce and exponent shift steps; depends on modexp_pkg.
module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status.exp_zero) begin
          state_next = ST_DONE;
        end else if (status.exp_lsb) begin
          state_next = ST_MUL_ACC;
        end else begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        cmd.mul     = 1'b1;
        cmd.sel_acc = 1'b1;
        state_next  = ST_RED_ACC;
      end
      ST_RED_ACC: begin
        cmd.red    = 1'b1;
        cmd.wr_acc = 1'b1;
        if (status.red_last) begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd.mul    = 1'b1;
        state_next = ST_RED_SQ;
      end
      ST_RED_SQ: begin
        cmd.red = 1'b1;
        if (status.red_last) begin
          cmd.shift  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

// File: rtl/core/modexp_dp.sv
// Datapath for the modular exponentiation block.
// Holds operands, one registered multiplier and a two-bit-per-cycle
// shift-subtract remainder unit; depends on modexp_pkg.
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = 63,
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [MOD_BITS-1:0] base,
  input  logic [EXP_BITS-1:0] exponent,
  input  logic [MOD_BITS-1:0] modulus,
  output logic [MOD_BITS-1:0] power_mod
);

  localparam int PROD_W = 2 * MOD_BITS;
  localparam int CNT_W  = $clog2(MOD_BITS);

  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] pw;
  logic [MOD_BITS-1:0] m;
  logic [EXP_BITS-1:0] e;
  logic [PROD_W-1:0]   prod;
  logic [MOD_BITS-1:0] r;
  logic [CNT_W-1:0]    cnt;

  logic [MOD_BITS-1:0] mul_a;
  logic [MOD_BITS:0]   mx;
  logic [MOD_BITS:0]   t1;
  logic [MOD_BITS:0]   s1;
  logic [MOD_BITS:0]   t2;
  logic [MOD_BITS:0]   s2;
  logic [MOD_BITS-1:0] r_next;
  logic [MOD_BITS-1:0] red_res;
  logic                red_last;

  assign mul_a    = cmd.sel_acc ? acc : pw;
  assign mx       = {1'b0, m};
  assign t1       = {r, prod[PROD_W-1]};
  assign s1       = (t1 >= mx) ? (t1 - mx) : t1;
  assign t2       = {s1[MOD_BITS-1:0], prod[PROD_W-2]};
  assign s2       = (t2 >= mx) ? (t2 - mx) : t2;
  assign r_next   = s2[MOD_BITS-1:0];
  assign red_res  = (m == '0) ? '0 : r_next;
  assign red_last = (cnt == CNT_W'(MOD_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= MOD_BITS'(1);
      pw  <= base;
      e   <= exponent;
      m   <= modulus;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mul_a) * PROD_W'(pw);
      r    <= '0;
      cnt  <= '0;
    end
    if (cmd.red) begin
      prod <= {prod[PROD_W-3:0], 2'b00};
      r    <= r_next;
      cnt  <= cnt + CNT_W'(1);
      if (red_last) begin
        if (cmd.wr_acc) begin
          acc <= red_res;
        end else begin
          pw <= red_res;
        end
      end
    end
    if (cmd.shift) begin
      e <= e >> 1;
    end
  end

  assign status.exp_zero = (e == '0);
  assign status.exp_lsb  = e[0];
  assign status.red_last = red_last;
  assign power_mod       = acc;

endmodule

// File: rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Joins modexp_ctrl and modexp_dp; depends on modexp_pkg.
//
// Usage: drive base, exponent and modulus and raise start while busy is
// low; the request is taken at that clock edge and busy stays high until
// the result has been shown. The result on power_mod is marked by done,
// high for exactly one cycle; the receiver cannot stall and must take it.
// Exponent zero returns 1 without reduction; modulus zero returns 0 for a
// nonzero exponent.
// The exponent is scanned from bit 0 up to its highest set bit. For each
// scanned bit the controller passes a check state; when the bit is set,
// it multiplies into the result and reduces, then it squares and reduces.
// The remainder unit takes two quotient bits per cycle over the
// 2*MOD_BITS product. One request is in work at a time. Synchronous
// reset returns the controller to idle and drops any request in work.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = 63,
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MOD_BITS-1:0] base,
  input  logic [EXP_BITS-1:0] exponent,
  input  logic [MOD_BITS-1:0] modulus,
  output logic                done,
  output logic [MOD_BITS-1:0] power_mod
);

  dp_cmd_t    cmd;
  dp_status_t status;

  modexp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  modexp_dp #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .base      (base),
    .exponent  (exponent),
    .modulus   (modulus),
    .power_mod (power_mod)
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for modular_exponentiation: a directed table, then random
// requests in several sender-idle phases, checked against typed table values or a
// square-and-multiply predictor. Depends only on the RTL under rtl/core.
module tb_top;

  localparam int EXP_W = 63;
  localparam int MOD_W = 31;
  localparam int RANDOM_REQUESTS = 120;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int NUM_ROWS = 18;
  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

  typedef struct packed {
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] exponent;
    logic [MOD_W-1:0] modulus;
    logic             typed;
    logic [MOD_W-1:0] power;
  } request_row_t;

  localparam request_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{31'd5, 63'd0, 31'd1, 1'b1, 31'd1},
    '{31'd0, 63'd0, 31'd7, 1'b1, 31'd1},
    '{31'd7, 63'd1, 31'd0, 1'b1, 31'd0},
    '{31'd7, 63'd0, 31'd0, 1'b1, 31'd1},
    '{MOD_MAX, 63'd1, MOD_MAX, 1'b1, 31'd0},
    '{MOD_MAX, 63'd2, MOD_MAX - 31'd1, 1'b0, 31'd0},
    '{31'd0, 63'd5, 31'd13, 1'b1, 31'd0},
    '{31'd3, 63'd4, 31'd100, 1'b1, 31'd81},
    '{31'd100, 63'd1, 31'd7, 1'b1, 31'd2},
    '{31'd2, EXP_MAX, MOD_MAX, 1'b0, 31'd0},
    '{MOD_MAX, EXP_MAX, MOD_MAX - 31'd2, 1'b0, 31'd0},
    '{31'd1, EXP_MAX, 31'd1, 1'b1, 31'd0},
    '{31'd5, 63'd1, 31'd1, 1'b1, 31'd0},
    '{31'd2, 63'h4000000000000000, 31'd1000003, 1'b0, 31'd0},
    '{31'h2AAAAAAA, 63'h5555555555555555, 31'h55555555, 1'b0, 31'd0},
    '{31'h55555555, 63'h2AAAAAAAAAAAAAAA, 31'h2AAAAAAB, 1'b0, 31'd0},
    '{31'd123456789, 63'd65537, MOD_MAX, 1'b0, 31'd0},
    '{31'd2, 63'd10, 31'd1025, 1'b1, 31'd1024}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [MOD_W-1:0] base = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic [MOD_W-1:0] modulus = '0;
  logic             done;
  logic [MOD_W-1:0] power_mod;

  logic [MOD_W-1:0] pending_power[$];
  int unsigned      failures = 0;
  int unsigned      cycle_count = 0;

  modular_exponentiation #(
    .EXP_BITS(EXP_W),
    .MOD_BITS(MOD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base(base),
    .exponent(exponent),
    .modulus(modulus),
    .done(done),
    .power_mod(power_mod)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] mod_reduce(input logic [63:0] x, input logic [MOD_W-1:0] m);
    if (m == '0) begin
      return 64'd0;
    end
    return x % {{(64-MOD_W){1'b0}}, m};
  endfunction

  function automatic logic [MOD_W-1:0] square_multiply_power(input logic [MOD_W-1:0] b,
                                                             input logic [EXP_W-1:0] e,
                                                             input logic [MOD_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] pw;
    acc = 64'd1;
    pw = {{(64-MOD_W){1'b0}}, b};
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) begin
        acc = mod_reduce(acc * pw, m);
      end
      pw = mod_reduce(pw * pw, m);
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic issue_request(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
                               input logic [MOD_W-1:0] m, input logic [MOD_W-1:0] want);
    base <= b;
    exponent <= e;
    modulus <= m;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_power.push_back(want);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_power.size() != 0) @(posedge clk);
  endtask

  task automatic sender_gap(input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 400)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic random_request(input int idle_pct);
    logic [63:0]      raw_exp;
    logic [MOD_W-1:0] b;
    logic [EXP_W-1:0] e;
    logic [MOD_W-1:0] m;
    int               sel;
    int               exp_width;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      exp_width = EXP_W;
    end else if (sel < 30) begin
      exp_width = $urandom_range(13, 32);
    end else begin
      exp_width = $urandom_range(0, 12);
    end
    raw_exp = {$urandom, $urandom};
    if (exp_width < 64) begin
      raw_exp = raw_exp & ((64'd1 << exp_width) - 64'd1);
    end
    e = raw_exp[EXP_W-1:0];
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = 31'd1;
      2: b = MOD_MAX;
      3: b = MOD_W'($urandom_range(2, 300));
      default: b = MOD_W'($urandom);
    endcase
    case ($urandom_range(0, 19))
      0: m = '0;
      1: m = 31'd1;
      2: m = MOD_MAX;
      3, 4, 5, 6: m = MOD_W'($urandom_range(2, 64));
      default: m = MOD_W'($urandom);
    endcase
    issue_request(b, e, m, square_multiply_power(b, e, m));
    if ($urandom_range(0, 29) == 0) begin
      drain_results();
    end else begin
      sender_gap(idle_pct);
    end
  endtask

  always @(posedge clk) begin : check_results
    logic [MOD_W-1:0] want;
    if (!rst && done === 1'b1) begin
      if (pending_power.size() == 0) begin
        $error("power_mod: expected no result, got %0d", power_mod);
        failures++;
      end else begin
        want = pending_power.pop_front();
        if (power_mod !== want) begin
          $error("power_mod: expected %0d, got %0d", want, power_mod);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_pct [4];
    idle_pct = '{0, 56, 0, 22};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_ROWS[i]) begin
      issue_request(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent, DIRECTED_ROWS[i].modulus,
                    DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].power :
                    square_multiply_power(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent,
                                          DIRECTED_ROWS[i].modulus));
      sender_gap(30);
    end
    drain_results();
    foreach (idle_pct[p]) begin
      for (int n = 0; n < RANDOM_REQUESTS / 4; n++) begin
        random_request(idle_pct[p]);
      end
      drain_results();
    end
    start <= 1'b0;
    while (pending_power.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/modexp_pkg.sv
rtl/core/modexp_ctrl.sv
rtl/core/modexp_dp.sv
rtl/core/modular_exponentiation.sv
tb/sv/tb_top.sv
